// ===== rtl/escaped_api_frame_deframer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Escaped API frame deframer - assertion macros
// Shared concurrent assertion helpers, clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_API_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define ESCAPED_API_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// Check that cond_b holds in the same cycle whenever cond_a holds.
`define EADF_ASSERT_SAME(name, cond_a, cond_b) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond_a) |-> (cond_b)) else $error("eadf assertion failed");

// Check that cond_b holds in the cycle after cond_a holds.
`define EADF_ASSERT_NEXT(name, cond_a, cond_b) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond_a) |=> (cond_b)) else $error("eadf assertion failed");

`endif

// ===== rtl/eadf_pkg.sv =====
// ----------------------------------------------------------------------------
// eadf_pkg
// Types and constants shared by the escaped API frame deframer.
// ----------------------------------------------------------------------------
package eadf_pkg;

  // Framing bytes
  localparam logic [7:0] ByteDelim   = 8'h7E;
  localparam logic [7:0] ByteEsc     = 8'h7D;
  localparam logic [7:0] EscFlip     = 8'h20;
  localparam logic [7:0] SumGood     = 8'hFF;
  localparam logic [7:0] SyncHiLimit = 8'd2;

  // Largest accepted payload length
  localparam int unsigned MaxPayloadDefault = 255;

  // Configuration register map
  localparam int unsigned CfgAddrW = 3;
  localparam logic [0:0]  RegEscapedMode = 1'b0;

  // Result kinds
  localparam logic [1:0] KindData    = 2'd0;
  localparam logic [1:0] KindOk      = 2'd1;
  localparam logic [1:0] KindCsumErr = 2'd2;
  localparam logic [1:0] KindLenErr  = 2'd3;

  // Configuration handed from the register block to the datapath
  typedef struct packed {
    logic escaped_mode;
  } cfg_t;

endpackage

// ===== rtl/escaped_api_frame_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// escaped_api_frame_deframer_unit
// Byte-stream API frame receiver with optional 0x7D escape decoding.
// ----------------------------------------------------------------------------
// Path: each byte passes the input register, then the result register,
//   which holds its result.
// Throughput: one byte per cycle unless out_stall_i holds a result; the state update sets it.
// Reset: rst_ni clears the frame state to hunting and escaped_mode to 0;
//   no clearing pass, bytes are taken right after reset.
module escaped_api_frame_deframer_unit #(
  parameter int unsigned MaxPayload = eadf_pkg::MaxPayloadDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [eadf_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic [1:0]                    kind_o
);

  eadf_pkg::cfg_t cfg;

  // Configuration registers
  eadf_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Deframing datapath
  eadf_core #(
    .MaxPayload (MaxPayload)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .kind_o      (kind_o)
  );

endmodule

// ===== rtl/eadf_apb_regs.sv =====
// ----------------------------------------------------------------------------
// eadf_apb_regs
// APB-style configuration register block holding the escaped_mode bit.
// ----------------------------------------------------------------------------
module eadf_apb_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [eadf_pkg::CfgAddrW-1:0]    paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output eadf_pkg::cfg_t                   cfg_o
);

  logic escaped_mode_q;
  logic escaped_mode_d;
  logic wr_en;
  logic sel_mode;

  assign pready   = 1'b1;
  assign sel_mode = (paddr[eadf_pkg::CfgAddrW-1:2] == eadf_pkg::RegEscapedMode);
  assign wr_en    = psel && penable && pwrite && pready;

  // Update the mode bit on a completed write transaction
  always_comb begin
    escaped_mode_d = escaped_mode_q;
    if (wr_en && sel_mode) begin
      escaped_mode_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escaped_mode_q <= 1'b0;
    end else begin
      escaped_mode_q <= escaped_mode_d;
    end
  end

  // Read back the register, zero elsewhere
  always_comb begin
    prdata = 32'd0;
    if (sel_mode) begin
      prdata = {31'd0, escaped_mode_q};
    end
  end

  assign cfg_o.escaped_mode = escaped_mode_q;

endmodule

// ===== rtl/eadf_core.sv =====
// ----------------------------------------------------------------------------
// eadf_core
// Input register, per-byte deframing state machine and result register.
// ----------------------------------------------------------------------------
`include "escaped_api_frame_deframer_unit_defines.svh"

module eadf_core #(
  parameter int unsigned MaxPayload = eadf_pkg::MaxPayloadDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  eadf_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     rx_byte_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic [1:0]     kind_o
);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_DATA   = 3'd3,
    PH_CSUM   = 3'd4
  } phase_e;

  localparam logic [7:0] MaxLen = 8'(MaxPayload);

  // Input stage
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_take;
  logic       advance;

  // Deframer state
  phase_e     phase_q, phase_d, phase_eff;
  logic       esc_q, esc_d;
  logic       too_big_q, too_big_d;
  logic [7:0] left_q, left_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] left_dec;
  logic [7:0] cur_byte;

  // Result stage
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic [1:0] out_kind_q;
  logic       res_valid;
  logic [7:0] res_byte;
  logic [1:0] res_kind;

  // Move the held byte forward once the result register has room
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign left_dec   = left_q - 8'd1;

  // Next state and result for the held byte
  always_comb begin
    phase_d   = phase_q;
    esc_d     = esc_q;
    too_big_d = too_big_q;
    left_d    = left_q;
    sum_d     = sum_q;
    res_valid = 1'b0;
    res_byte  = 8'd0;
    res_kind  = eadf_pkg::KindData;
    cur_byte  = in_byte_q;
    phase_eff = phase_q;

    // Failed sync check: examine this byte again as a delimiter
    if (phase_q == PH_LEN_HI && !cfg_i.escaped_mode && in_byte_q > eadf_pkg::SyncHiLimit) begin
      phase_eff = PH_HUNT;
    end

    unique case (phase_eff)
      PH_LEN_HI, PH_LEN_LO, PH_DATA, PH_CSUM: begin
        if (esc_q) begin
          cur_byte = in_byte_q ^ eadf_pkg::EscFlip;
          esc_d    = 1'b0;
        end
        if (!esc_q && cfg_i.escaped_mode && in_byte_q == eadf_pkg::ByteEsc) begin
          // Drop the escape byte and flip the next one
          esc_d = 1'b1;
        end else begin
          unique case (phase_eff)
            PH_LEN_HI: begin
              too_big_d = (cur_byte != 8'd0);
              phase_d   = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              if (too_big_q || cur_byte > MaxLen) begin
                phase_d   = PH_HUNT;
                esc_d     = 1'b0;
                too_big_d = 1'b0;
                left_d    = 8'd0;
                sum_d     = 8'd0;
                res_valid = 1'b1;
                res_kind  = eadf_pkg::KindLenErr;
              end else begin
                left_d  = cur_byte;
                sum_d   = 8'd0;
                phase_d = (cur_byte == 8'd0) ? PH_CSUM : PH_DATA;
              end
            end
            PH_DATA: begin
              sum_d     = sum_q + cur_byte;
              left_d    = left_dec;
              res_valid = 1'b1;
              res_byte  = cur_byte;
              res_kind  = eadf_pkg::KindData;
              if (left_dec == 8'd0) begin
                phase_d = PH_CSUM;
              end
            end
            default: begin
              // Checksum byte closes the frame
              phase_d   = PH_HUNT;
              esc_d     = 1'b0;
              too_big_d = 1'b0;
              left_d    = 8'd0;
              sum_d     = 8'd0;
              res_valid = 1'b1;
              res_kind  = (8'(sum_q + cur_byte) == eadf_pkg::SumGood) ?
                          eadf_pkg::KindOk : eadf_pkg::KindCsumErr;
            end
          endcase
        end
      end
      default: begin
        // Hunt for the delimiter with all frame state cleared
        phase_d   = (in_byte_q == eadf_pkg::ByteDelim) ? PH_LEN_HI : PH_HUNT;
        esc_d     = 1'b0;
        too_big_d = 1'b0;
        left_d    = 8'd0;
        sum_d     = 8'd0;
      end
    endcase
  end

  // Hold input, state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PH_HUNT;
      esc_q       <= 1'b0;
      too_big_q   <= 1'b0;
      left_q      <= 8'd0;
      sum_q       <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        phase_q     <= phase_d;
        esc_q       <= esc_d;
        too_big_q   <= too_big_d;
        left_q      <= left_d;
        sum_q       <= sum_d;
        out_valid_q <= res_valid;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
    if (advance) begin
      out_byte_q <= res_byte;
      out_kind_q <= res_kind;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign kind_o      = out_kind_q;

  `EADF_ASSERT_SAME(a_end_byte_zero, out_valid_q && out_kind_q != eadf_pkg::KindData, out_byte_q == 8'd0)
  `EADF_ASSERT_SAME(a_hunt_no_escape, phase_q == PH_HUNT, !esc_q && !too_big_q)
  `EADF_ASSERT_SAME(a_data_has_bytes, phase_q == PH_DATA, left_q != 8'd0)
  `EADF_ASSERT_NEXT(a_blocked_byte_kept, in_valid_q && out_valid_q && out_stall_i, in_valid_q)

endmodule

// ===== bench/eadf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eadf_checker
// Watches the configuration port and both byte channels of the deframer,
// keeps its own model of the framing state, and compares every result
// transaction field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module eadf_checker #(
  parameter int unsigned MaxPayload = eadf_pkg::MaxPayloadDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [eadf_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  input  logic                          pready,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic [7:0]                    out_byte_o,
  input  logic [1:0]                    kind_o,
  output int unsigned                   pending_cnt_o,
  output int unsigned                   mismatch_cnt_o
);

  localparam int unsigned AddrW = eadf_pkg::CfgAddrW;
  localparam logic [AddrW-1:0] EscModeAddr = AddrW'(4 * eadf_pkg::RegEscapedMode);

  typedef enum logic [2:0] {
    PhHunt,
    PhLenHi,
    PhLenLo,
    PhData,
    PhCsum
  } frame_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
  } frame_result_t;

  frame_result_t frame_result_q[$];
  frame_phase_e  phase;
  logic          esc_mode;
  logic          esc_pending;
  logic          len_big;
  logic [7:0]    bytes_left;
  logic [7:0]    frame_sum;
  int unsigned   mismatch_cnt;

  assign mismatch_cnt_o = mismatch_cnt;

  // Drop any partial frame and go back to looking for a delimiter
  task automatic restart_hunt();
    phase       = PhHunt;
    esc_pending = 1'b0;
    len_big     = 1'b0;
    bytes_left  = '0;
    frame_sum   = '0;
  endtask

  // Advance the framing state by one received byte, queue any result
  task automatic deframe_byte(input logic [7:0] raw);
    logic [7:0] b;
    logic [7:0] total;
    // Unescaped mode: a large length high byte means a false delimiter
    if (phase == PhLenHi && !esc_mode && raw > eadf_pkg::SyncHiLimit) restart_hunt();
    if (phase == PhHunt) begin
      restart_hunt();
      if (raw == eadf_pkg::ByteDelim) phase = PhLenHi;
      return;
    end
    // Undo escaping; a pending escape applies whatever the mode is now
    if (esc_pending) begin
      b = raw ^ eadf_pkg::EscFlip;
      esc_pending = 1'b0;
    end else if (esc_mode && raw == eadf_pkg::ByteEsc) begin
      esc_pending = 1'b1;
      return;
    end else begin
      b = raw;
    end
    case (phase)
      PhLenHi: begin
        len_big = (b != 8'h00);
        phase   = PhLenLo;
      end
      PhLenLo: begin
        if (len_big || int'(b) > int'(MaxPayload)) begin
          restart_hunt();
          frame_result_q.insert(frame_result_q.size(),
                                '{data: 8'h00, kind: eadf_pkg::KindLenErr});
        end else begin
          bytes_left = b;
          frame_sum  = '0;
          phase      = (b == 8'h00) ? PhCsum : PhData;
        end
      end
      PhData: begin
        frame_sum  = frame_sum + b;
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'h00) phase = PhCsum;
        frame_result_q.insert(frame_result_q.size(),
                              '{data: b, kind: eadf_pkg::KindData});
      end
      default: begin
        total = frame_sum + b;
        restart_hunt();
        frame_result_q.insert(frame_result_q.size(),
                              '{data: 8'h00,
                                kind: (total == eadf_pkg::SumGood) ?
                                      eadf_pkg::KindOk : eadf_pkg::KindCsumErr});
      end
    endcase
  endtask

  // Track config writes, predict on input transactions, check output ones
  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    if (!rst_ni) begin
      restart_hunt();
      esc_mode = 1'b0;
      frame_result_q.delete();
      mismatch_cnt = 0;
      pending_cnt_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == EscModeAddr) begin
        esc_mode = pwdata[0];
      end
      if (in_valid_i && !in_stall_o) deframe_byte(rx_byte_i);
      if (out_valid_o && !out_stall_i) begin
        if (frame_result_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual byte %02h kind %0d",
                   $time, out_byte_o, kind_o);
          mismatch_cnt++;
        end else begin
          want = frame_result_q.pop_front();
          if (out_byte_o !== want.data) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, out_byte_o);
            mismatch_cnt++;
          end
          if (kind_o !== want.kind) begin
            $display("%0t: kind mismatch: expected %0d, actual %0d",
                     $time, want.kind, kind_o);
            mismatch_cnt++;
          end
        end
      end
      pending_cnt_o <= frame_result_q.size();
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the deframer with directed frames covering sync loss, zero length,
// length errors, escapes and a mode change mid-frame, then random frames in
// both modes with random idle cycles on each side; eadf_checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned AddrW = eadf_pkg::CfgAddrW;
  localparam logic [AddrW-1:0] EscModeAddr = AddrW'(4 * eadf_pkg::RegEscapedMode);
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned RandomItems = 500;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          rx_byte_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [7:0]          out_byte_o;
  logic [1:0]          kind_o;
  int unsigned         pending_cnt;
  int unsigned         mismatch_cnt;
  int unsigned         idle_cycles;

  logic [7:0]          frame_q[$];
  logic                cur_mode;
  bit                  send_quiet;
  bit                  recv_quiet;

  escaped_api_frame_deframer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .kind_o     (kind_o)
  );

  eadf_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .kind_o        (kind_o),
    .pending_cnt_o (pending_cnt),
    .mismatch_cnt_o(mismatch_cnt)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Random stall before each result transaction, with quiet stretches
  initial begin
    int n;
    out_stall_i = 1'b1;
    recv_quiet  = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      n = recv_quiet ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if ($urandom_range(0, 29) == 0) recv_quiet = !recv_quiet;
    end
  end

  // Two-phase register write
  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold off input until every predicted result has drained
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    repeat (3) @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic mode);
    wait_drained();
    cur_mode = mode;
    write_reg(EscModeAddr, {31'd0, mode});
  endtask

  // Send every byte of frame_q, one transaction each, with random gaps
  task automatic send_frame();
    int gap;
    foreach (frame_q[i]) begin
      gap = send_quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      rx_byte_i  <= frame_q[i];
      do @(posedge clk_i); while (in_stall_o);
    end
    frame_q.delete();
  endtask

  // Bias payload toward framing bytes and extremes
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) != 0) return 8'($urandom);
    case ($urandom_range(0, 5))
      0:       return eadf_pkg::ByteDelim;
      1:       return eadf_pkg::ByteEsc;
      2:       return 8'h00;
      3:       return 8'hFF;
      4:       return eadf_pkg::ByteDelim ^ eadf_pkg::EscFlip;
      default: return eadf_pkg::ByteEsc ^ eadf_pkg::EscFlip;
    endcase
  endfunction

  // Append a byte, escaping it in escaped mode when needed or at random
  task automatic add_byte(input logic [7:0] b, input logic esc_on);
    if (esc_on && (b == eadf_pkg::ByteDelim || b == eadf_pkg::ByteEsc ||
                   $urandom_range(0, 15) == 0)) begin
      frame_q.insert(frame_q.size(), eadf_pkg::ByteEsc);
      frame_q.insert(frame_q.size(), b ^ eadf_pkg::EscFlip);
    end else begin
      frame_q.insert(frame_q.size(), b);
    end
  endtask

  // Mostly well-formed frames, some truncated, bad length or plain noise
  task automatic build_frame(input logic esc_on);
    int         sel;
    int         len;
    int         cut;
    logic [7:0] sum;
    logic [7:0] p;
    sel = $urandom_range(0, 99);
    if (sel < 85) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
      sum = 8'h00;
      frame_q.insert(frame_q.size(), eadf_pkg::ByteDelim);
      add_byte(8'h00, esc_on);
      add_byte(len[7:0], esc_on);
      for (int i = 0; i < len; i++) begin
        p = pick_byte();
        sum = sum + p;
        add_byte(p, esc_on);
      end
      p = eadf_pkg::SumGood - sum;
      if ($urandom_range(0, 7) == 0) p = 8'($urandom);
      add_byte(p, esc_on);
      // cut some frames short so the next one runs into them
      if (sel >= 75) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        frame_q = frame_q[0:cut-1];
      end
    end else if (sel < 93) begin
      frame_q.insert(frame_q.size(), eadf_pkg::ByteDelim);
      add_byte(8'($urandom_range(1, 255)), esc_on);
      add_byte(8'($urandom), esc_on);
    end else begin
      repeat ($urandom_range(1, 6)) frame_q.insert(frame_q.size(), pick_byte());
    end
  endtask

  initial begin
    int random_items;
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    rx_byte_i  = 8'h00;
    cur_mode   = 1'b0;
    send_quiet = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unescaped: false delimiter, delimiter re-examined, zero length, length error
    write_reg(EscModeAddr, 32'd0);
    frame_q = '{8'hFF, 8'h7E, 8'h05, 8'h7E, 8'h7E, 8'h00, 8'h00, 8'hFF,
                8'h7E, 8'h01, 8'h00};
    send_frame();

    // Escaped: escaped length, escaped payload, escape of an escape byte
    set_mode(1'b1);
    frame_q = '{8'h7E, 8'h00, 8'h7D, 8'h21, 8'h7D, 8'h5E, 8'h7D, 8'h7D};
    send_frame();

    // Leave an escape pending, clear the mode, then send a raw delimiter byte as payload
    frame_q = '{8'h7E, 8'h00, 8'h02, 8'h7D};
    send_frame();
    set_mode(1'b0);
    frame_q = '{8'h5E, 8'h7E, 8'h03};
    send_frame();

    // Random frames, switching mode now and then
    random_items = 0;
    while (random_items < RandomItems) begin
      if ($urandom_range(0, 9) == 0) set_mode(!cur_mode);
      else if ($urandom_range(0, 19) == 0) wait_drained();
      send_quiet = ($urandom_range(0, 3) == 0);
      build_frame(cur_mode);
      random_items += frame_q.size();
      send_frame();
    end

    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
